// ===== hdl/psv_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the polyphonic saw voice engine
package psv_pkg;

  localparam int LVL_W = 25;
  localparam int FLT_W = 24;
  localparam int PH_W = 32;
  localparam int MIX_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 25;
  localparam int KEY_COUNT = 128;

  localparam logic [LVL_W-1:0] ONE_Q24 = 25'h1000000;

  localparam logic CMD_MIDI = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON = 4'h9;
  localparam logic [3:0] MIDI_CTRL = 4'hB;
  localparam logic [6:0] CTRL_ALL_OFF = 7'd123;

  localparam logic [63:0] SEMI_UP = 64'd4550359342;
  localparam logic [63:0] SEMI_DOWN = 64'd4053909305;
  localparam logic [63:0] HALF_Q32 = 64'h80000000;
  localparam logic [63:0] A4_HZ_Q16 = 64'd440 << 16;
  localparam int A4_KEY = 69;

  // exact reciprocals: 30-bit dividend by 127 and by 5
  localparam logic [30:0] RECIP_127 = 31'd1082196485;
  localparam int RECIP_127_SH = 37;
  localparam logic [30:0] RECIP_5 = 31'd1717986919;
  localparam int RECIP_5_SH = 33;

  typedef enum logic [2:0] {
    STG_OFF     = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWPASS = 3'd0,
    CFG_ATTACK  = 3'd1,
    CFG_DECAY   = 3'd2,
    CFG_RELEASE = 3'd3,
    CFG_SUSTAIN = 3'd4,
    CFG_GAIN    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    stage_t                    stage;
    logic [6:0]                key;
    logic [6:0]                vel;
    logic [PH_W-1:0]           phase;
    logic [LVL_W-1:0]          level;
    logic signed [FLT_W-1:0]   filter;
  } voice_t;

  typedef struct packed {
    logic [15:0]      coeff;
    logic [LVL_W-1:0] attack;
    logic [LVL_W-1:0] fall;
    logic [LVL_W-1:0] rel;
    logic [LVL_W-1:0] sus;
  } env_cfg_t;

  typedef logic [PH_W-1:0] rom_t [KEY_COUNT];

endpackage

// ===== hdl/psv_if.sv =====
`timescale 1ns / 1ps
// input and result channel interfaces
interface psv_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] midi_status;
  logic [6:0] midi_data1;
  logic [6:0] midi_data2;

  modport source (output valid, command, midi_status, midi_data1, midi_data2, input ready);
  modport sink (input valid, command, midi_status, midi_data1, midi_data2, output ready);
endinterface

interface psv_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;
  logic               clipped;

  modport source (output valid, sample, clipped, input ready);
  modport sink (input valid, sample, clipped, output ready);
endinterface

// ===== hdl/psv_voice_ram.sv =====
`timescale 1ns / 1ps
// voice state memory with per-entry valid bits, registered read
module psv_voice_ram #(
  parameter int VOICE_COUNT = 8,
  parameter int AW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output psv_pkg::voice_t     rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  psv_pkg::voice_t     wr_data
);
  import psv_pkg::*;

  voice_t mem [VOICE_COUNT];
  voice_t rd_q_r;
  logic [VOICE_COUNT-1:0] valid_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== hdl/psv_voice_pipe.sv =====
`timescale 1ns / 1ps
// per-voice tick datapath: envelope, saw, drive scaling, lowpass, accumulate
module psv_voice_pipe #(
  parameter int FS_HZ = 48000,
  parameter int AW = 3,
  parameter int ACC_W = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [AW-1:0]           in_idx,
  input  psv_pkg::voice_t         in_voice,
  input  psv_pkg::env_cfg_t       cfg,
  input  logic                    acc_clr,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output psv_pkg::voice_t         wr_data,
  output logic                    busy,
  output logic signed [ACC_W-1:0] acc
);
  import psv_pkg::*;

  function automatic rom_t build_rom();
    logic [63:0] hz [KEY_COUNT];
    logic [63:0] inc;
    rom_t rom;
    hz[A4_KEY] = A4_HZ_Q16;
    for (int n = A4_KEY + 1; n < KEY_COUNT; n++) begin
      hz[n] = (hz[n-1] * SEMI_UP + HALF_Q32) >> 32;
    end
    for (int n = A4_KEY - 1; n >= 0; n--) begin
      hz[n] = (hz[n+1] * SEMI_DOWN + HALF_Q32) >> 32;
    end
    for (int n = 0; n < KEY_COUNT; n++) begin
      inc = ((hz[n] << 16) + 64'(FS_HZ / 2)) / 64'(FS_HZ);
      rom[n] = (inc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : inc[31:0];
    end
    return rom;
  endfunction

  localparam rom_t PITCH = build_rom();

  // stage a: envelope, phase, saw
  logic signed [26:0] lv, t_lv, sus_s;
  stage_t stg_n;
  voice_t va;
  logic signed [25:0] saw;

  always_comb begin
    sus_s = $signed({2'b0, cfg.sus});
    lv = $signed({2'b0, in_voice.level});
    stg_n = in_voice.stage;
    t_lv = lv;
    case (in_voice.stage)
      STG_ATTACK: begin
        t_lv = lv + $signed({2'b0, cfg.attack});
        if (t_lv >= $signed({2'b0, ONE_Q24})) begin
          t_lv = $signed({2'b0, ONE_Q24});
          stg_n = STG_DECAY;
        end
      end
      STG_DECAY: begin
        t_lv = lv - $signed({2'b0, cfg.fall});
        if (t_lv <= sus_s) begin
          t_lv = sus_s;
          stg_n = STG_SUSTAIN;
        end
      end
      STG_SUSTAIN: t_lv = sus_s;
      STG_RELEASE: begin
        t_lv = lv - $signed({2'b0, cfg.rel});
        if (t_lv <= 27'sd0) begin
          t_lv = 27'sd0;
          stg_n = STG_OFF;
        end
      end
      default: t_lv = lv;
    endcase
    va = in_voice;
    va.stage = stg_n;
    va.level = t_lv[LVL_W-1:0];
    va.phase = in_voice.phase + PITCH[in_voice.key];
    saw = $signed({1'b0, in_voice.phase[31:7]}) - 26'sd16777216;
  end

  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r;
  logic a_act_r, b_act_r, c_act_r, d_act_r, e_act_r;
  logic [AW-1:0] a_idx_r, b_idx_r, c_idx_r, d_idx_r, e_idx_r;
  voice_t a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;
  logic signed [25:0] a_saw_r;
  logic signed [51:0] b_p1_r;
  logic [29:0] c_u_r;
  logic c_neg_r;
  logic signed [24:0] d_x_r;
  logic signed [42:0] e_prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [59:0] p2;
  logic [59:0] mag;
  logic [60:0] q_full;
  logic [23:0] q;
  logic signed [24:0] x;
  logic signed [25:0] dif;
  logic signed [42:0] sh;
  logic signed [26:0] fn_w;
  logic signed [FLT_W-1:0] fn;

  always_comb begin
    p2 = b_p1_r * $signed({1'b0, b_v_r.vel});
    mag = p2[59] ? 60'(-p2) : 60'(p2);
    q_full = c_u_r * RECIP_127;
    q = q_full[60:RECIP_127_SH];
    x = c_neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    dif = $signed({d_x_r[24], d_x_r}) - $signed({{2{d_v_r.filter[23]}}, d_v_r.filter});
    sh = e_prod_r >>> 16;
    fn_w = $signed({{3{e_v_r.filter[23]}}, e_v_r.filter}) + sh[26:0];
    fn = fn_w[FLT_W-1:0];
  end

  always_ff @(posedge clk) begin
    a_idx_r <= in_idx;
    a_v_r <= va;
    a_saw_r <= saw;
    b_idx_r <= a_idx_r;
    b_v_r <= a_v_r;
    b_p1_r <= a_saw_r * $signed({1'b0, a_v_r.level});
    c_idx_r <= b_idx_r;
    c_v_r <= b_v_r;
    c_u_r <= mag[54:25];
    c_neg_r <= p2[59];
    d_idx_r <= c_idx_r;
    d_v_r <= c_v_r;
    d_x_r <= x;
    e_idx_r <= d_idx_r;
    e_v_r <= d_v_r;
    e_prod_r <= $signed({1'b0, cfg.coeff}) * dif;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      a_act_r <= 1'b0;
      b_act_r <= 1'b0;
      c_act_r <= 1'b0;
      d_act_r <= 1'b0;
      e_act_r <= 1'b0;
      acc_r <= '0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      a_act_r <= in_voice.stage != STG_OFF;
      b_act_r <= a_act_r;
      c_act_r <= b_act_r;
      d_act_r <= c_act_r;
      e_act_r <= d_act_r;
      if (acc_clr) begin
        acc_r <= '0;
      end else if (e_vld_r && e_act_r) begin
        acc_r <= acc_r + ACC_W'(fn);
      end
    end
  end

  always_comb begin
    wr_data = e_v_r;
    wr_data.filter = fn;
  end

  assign wr_en = e_vld_r && e_act_r;
  assign wr_addr = e_idx_r;
  assign busy = a_vld_r || b_vld_r || c_vld_r || d_vld_r || e_vld_r;
  assign acc = acc_r;

endmodule

// ===== hdl/psv_mix.sv =====
`timescale 1ns / 1ps
// mix scaling by gain / 5, floor, and 24-bit saturation
module psv_mix #(
  parameter int ACC_W = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] acc,
  input  logic [15:0]             gain,
  output logic                    done,
  output logic signed [23:0]      sample,
  output logic                    clipped
);
  import psv_pkg::*;

  logic m1_vld_r, m2_vld_r, m3_vld_r;
  logic signed [47:0] m1_p_r;
  logic [29:0] m2_u_r;
  logic m2_neg_r;
  logic signed [23:0] sample_r;
  logic clip_r;

  logic signed [MIX_W-1:0] acc_x;
  logic signed [31:0] v;
  logic [31:0] u;
  logic [60:0] q_full;
  logic [27:0] q;
  logic signed [28:0] y;

  always_comb begin
    acc_x = MIX_W'(acc);
    v = m1_p_r[47:16];
    u = v[31] ? 32'(-v + 32'sd4) : 32'(v);
    q_full = m2_u_r * RECIP_5;
    q = q_full[60:RECIP_5_SH];
    y = m2_neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    m1_p_r <= acc_x * $signed({1'b0, gain});
    m2_u_r <= u[29:0];
    m2_neg_r <= v[31];
    if (m2_vld_r) begin
      if (y > 29'sd8388607) begin
        sample_r <= 24'sh7FFFFF;
        clip_r <= 1'b1;
      end else if (y < -29'sd8388608) begin
        sample_r <= 24'sh800000;
        clip_r <= 1'b1;
      end else begin
        sample_r <= y[23:0];
        clip_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= start;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  assign done = m3_vld_r;
  assign sample = sample_r;
  assign clipped = clip_r;

endmodule

// ===== hdl/poly_saw_adsr_voice_engine.sv =====
`timescale 1ns / 1ps
// top level: eight-voice saw/adsr synth engine with voice state in memory
//
// in_if carries one beat per item: a midi message (command 0) or a sample
// tick (command 1). out_if carries one beat per tick: the mixed sample and
// a clip flag. cfg_we/cfg_index/cfg_data write a register. all voice state
// sits in one memory read and written one voice per cycle. a note-on,
// note-off or all-notes-off message sweeps every voice, other midi messages
// are dropped; a note-on then reads and writes the chosen voice. a tick
// reads voice after voice into a five-stage datapath and then a three-stage
// mix. one item is worked on at a time.
// the result waits in an output register; new items are accepted while it
// waits, but a tick does not finish until the previous result was taken.
// reset clears all voices to off, loads default registers and empties
// the output register.
module poly_saw_adsr_voice_engine #(
  parameter int VOICE_COUNT = 8,
  parameter int FS_HZ = 48000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  psv_in_if.sink                              in_if,
  psv_out_if.source                           out_if,
  input  logic                                cfg_we,
  input  logic [psv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psv_pkg::*;

  localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ACC_W = FLT_W + AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(VOICE_COUNT - 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SWEEP   = 9'b000000010,
    ST_LAST    = 9'b000000100,
    ST_PICK_RD = 9'b000001000,
    ST_PICK_WR = 9'b000010000,
    ST_TICK    = 9'b000100000,
    ST_DRAIN   = 9'b001000000,
    ST_MIX     = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  // configuration
  logic [15:0] coeff_r, gain_r;
  logic [LVL_W-1:0] attack_r, decay_r, release_r, sustain_r, fall_r;
  logic [LVL_W-1:0] sus;
  logic [49:0] fall_prod;
  env_cfg_t env_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= 16'd31590;
      attack_r <= 25'd34953;
      decay_r <= 25'd3495;
      release_r <= 25'd1165;
      sustain_r <= 25'd11744051;
      gain_r <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWPASS: coeff_r <= cfg_data[15:0];
        CFG_ATTACK:  attack_r <= cfg_data;
        CFG_DECAY:   decay_r <= cfg_data;
        CFG_RELEASE: release_r <= cfg_data;
        CFG_SUSTAIN: sustain_r <= cfg_data;
        CFG_GAIN:    gain_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign sus = (sustain_r > ONE_Q24) ? ONE_Q24 : sustain_r;
  assign fall_prod = decay_r * (ONE_Q24 - sus);

  always_ff @(posedge clk) begin
    fall_r <= fall_prod[48:24];
  end

  always_comb begin
    env_cfg.coeff = coeff_r;
    env_cfg.attack = attack_r;
    env_cfg.fall = fall_r;
    env_cfg.rel = release_r;
    env_cfg.sus = sus;
  end

  // sequencer
  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic dvld_r;
  logic [AW-1:0] didx_r;
  logic [6:0] key_r, key_nxt, vel_r, vel_nxt;
  logic found_r, found_nxt, rel_found_r, rel_found_nxt;
  logic [AW-1:0] off_idx_r, off_idx_nxt, rel_idx_r, rel_idx_nxt;
  logic [AW-1:0] pick_r, pick_nxt;

  logic in_acc;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  voice_t rd_data;
  logic midi_we;
  voice_t midi_wdata;
  logic [AW-1:0] midi_waddr;
  logic pipe_we;
  logic [AW-1:0] pipe_waddr;
  voice_t pipe_wdata;
  logic pipe_busy;
  logic signed [ACC_W-1:0] acc;
  logic acc_clr, mix_start, mix_done;
  logic signed [23:0] mix_sample;
  logic mix_clip;
  logic out_valid_r, out_clip_r, out_load;
  logic signed [23:0] out_sample_r;
  logic [3:0] st_hi;
  logic pipe_in_vld;

  assign in_if.ready = state_r == ST_IDLE;
  assign in_acc = in_if.valid && in_if.ready;
  assign st_hi = in_if.midi_status[7:4];

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    key_nxt = key_r;
    vel_nxt = vel_r;
    found_nxt = found_r;
    rel_found_nxt = rel_found_r;
    off_idx_nxt = off_idx_r;
    rel_idx_nxt = rel_idx_r;
    pick_nxt = pick_r;
    rd_en = 1'b0;
    rd_addr = cnt_r;
    midi_we = 1'b0;
    midi_waddr = didx_r;
    midi_wdata = rd_data;
    acc_clr = 1'b0;
    mix_start = 1'b0;
    out_load = 1'b0;

    // sweep results of the previous read
    if (dvld_r && (state_r == ST_SWEEP || state_r == ST_LAST)) begin
      case (op_r)
        OP_NOTE_OFF: begin
          if (rd_data.stage != STG_OFF && rd_data.key == key_r && !found_r) begin
            midi_we = 1'b1;
            midi_wdata.stage = STG_RELEASE;
            found_nxt = 1'b1;
          end
        end
        OP_ALL_OFF: begin
          if (rd_data.stage != STG_OFF) begin
            midi_we = 1'b1;
            midi_wdata.stage = STG_RELEASE;
          end
        end
        OP_NOTE_ON: begin
          if (rd_data.stage == STG_OFF && !found_r) begin
            found_nxt = 1'b1;
            off_idx_nxt = didx_r;
          end
          if (rd_data.stage == STG_RELEASE && !rel_found_r) begin
            rel_found_nxt = 1'b1;
            rel_idx_nxt = didx_r;
          end
        end
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          found_nxt = 1'b0;
          rel_found_nxt = 1'b0;
          key_nxt = in_if.midi_data1;
          vel_nxt = in_if.midi_data2;
          if (in_if.command == CMD_TICK) begin
            op_nxt = OP_TICK;
            acc_clr = 1'b1;
            state_nxt = ST_TICK;
          end else if (st_hi == MIDI_NOTE_ON && in_if.midi_data2 != 7'd0) begin
            op_nxt = OP_NOTE_ON;
            state_nxt = ST_SWEEP;
          end else if (st_hi == MIDI_NOTE_OFF || st_hi == MIDI_NOTE_ON) begin
            op_nxt = OP_NOTE_OFF;
            state_nxt = ST_SWEEP;
          end else if (st_hi == MIDI_CTRL && in_if.midi_data1 == CTRL_ALL_OFF) begin
            op_nxt = OP_ALL_OFF;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        rd_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = (op_r == OP_NOTE_ON) ? ST_PICK_RD : ST_IDLE;
      end
      ST_PICK_RD: begin
        if (found_r) begin
          pick_nxt = off_idx_r;
        end else if (rel_found_r) begin
          pick_nxt = rel_idx_r;
        end else begin
          pick_nxt = '0;
        end
        rd_en = 1'b1;
        rd_addr = pick_nxt;
        state_nxt = ST_PICK_WR;
      end
      ST_PICK_WR: begin
        midi_we = 1'b1;
        midi_waddr = pick_r;
        midi_wdata = rd_data;
        midi_wdata.key = key_r;
        midi_wdata.vel = vel_r;
        midi_wdata.stage = STG_ATTACK;
        midi_wdata.phase = '0;
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        rd_en = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dvld_r && !pipe_busy) begin
          mix_start = 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mix_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_TICK;
      cnt_r <= '0;
      dvld_r <= 1'b0;
      found_r <= 1'b0;
      rel_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      cnt_r <= cnt_nxt;
      dvld_r <= rd_en;
      found_r <= found_nxt;
      rel_found_r <= rel_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= rd_addr;
    key_r <= key_nxt;
    vel_r <= vel_nxt;
    off_idx_r <= off_idx_nxt;
    rel_idx_r <= rel_idx_nxt;
    pick_r <= pick_nxt;
  end

  assign pipe_in_vld = dvld_r && op_r == OP_TICK && (state_r == ST_TICK || state_r == ST_DRAIN);

  psv_voice_ram #(
    .VOICE_COUNT(VOICE_COUNT),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(pipe_we || midi_we),
    .wr_addr(pipe_we ? pipe_waddr : midi_waddr),
    .wr_data(pipe_we ? pipe_wdata : midi_wdata)
  );

  psv_voice_pipe #(
    .FS_HZ(FS_HZ),
    .AW(AW),
    .ACC_W(ACC_W)
  ) u_pipe (
    .clk(clk),
    .rst_n(rst_n),
    .in_vld(pipe_in_vld),
    .in_idx(didx_r),
    .in_voice(rd_data),
    .cfg(env_cfg),
    .acc_clr(acc_clr),
    .wr_en(pipe_we),
    .wr_addr(pipe_waddr),
    .wr_data(pipe_wdata),
    .busy(pipe_busy),
    .acc(acc)
  );

  psv_mix #(
    .ACC_W(ACC_W)
  ) u_mix (
    .clk(clk),
    .rst_n(rst_n),
    .start(mix_start),
    .acc(acc),
    .gain(gain_r),
    .done(mix_done),
    .sample(mix_sample),
    .clipped(mix_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= mix_sample;
      out_clip_r <= mix_clip;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.sample = out_sample_r;
  assign out_if.clipped = out_clip_r;

  // checks
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(pipe_we && midi_we))
    else $error("voice memory written by tick and midi paths at once");

  a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_busy |-> (state_r == ST_TICK || state_r == ST_DRAIN))
    else $error("voice datapath busy outside a tick");

  a_mix_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mix_start |=> !pipe_busy && acc == $past(acc))
    else $error("mix started before the voice datapath drained");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_if.ready))
    else $error("result loaded over a beat not yet taken");

endmodule
